// ----- rtl/fat12_cluster_chain_walker_unit_assert.svh -----
// Assertion macros for the FAT12 chain walker.
`ifndef FAT12_CLUSTER_CHAIN_WALKER_UNIT_ASSERT_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define FCW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define FCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/fcw_pkg.sv -----
// Shared types and constants of the FAT12 chain walker.
package fcw_pkg;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STEP  = 2'd2;

    localparam logic [1:0] STATUS_VALID = 2'd0;
    localparam logic [1:0] STATUS_END   = 2'd1;
    localparam logic [1:0] STATUS_BAD   = 2'd2;

    localparam logic [0:0] REG_DATA_START = 1'd0;
    localparam logic [0:0] REG_SPC        = 1'd1;

    localparam logic [11:0] ENTRY_END     = 12'hFF8;
    localparam logic [11:0] FIRST_CLUSTER = 12'd2;

    localparam logic [31:0] DATA_START_RESET = 32'd33;
    localparam logic [7:0]  SPC_RESET        = 8'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_LO,
        ST_RD_HI,
        ST_PAIR,
        ST_CLASS,
        ST_MUL_WAIT,
        ST_DONE
    } fsm_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage

// ----- rtl/fcw_ram.sv -----
// Generic single-port RAM with registered read.
module fcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- rtl/fcw_mul.sv -----
// Shift-add unit: base + mcand * mult, one multiplier bit per cycle.
module fcw_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [11:0]       mcand,
    input  logic [7:0]        mult,
    input  logic [31:0]       base,
    output fcw_pkg::mul_stat_t stat,
    output logic [31:0]       result
);
    import fcw_pkg::*;

    logic [31:0] acc_reg, acc_next;
    logic [19:0] sh_reg, sh_next;
    logic [7:0]  m_reg, m_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    always_comb begin
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        m_next    = m_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next  = base;
            sh_next   = {8'd0, mcand};
            m_next    = mult;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (m_reg[0]) begin
                acc_next = acc_reg + {12'd0, sh_reg};
            end
            sh_next  = {sh_reg[18:0], 1'b0};
            m_next   = {1'b0, m_reg[7:1]};
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        m_reg   <= m_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = acc_reg;
endmodule

// ----- rtl/fat12_cluster_chain_walker_unit.sv -----
// Top level of the FAT12 cluster chain walker.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------------
//  input    | s_valid / s_ready    | s_kind, s_table_address, s_table_byte,
//           |                      | s_first_cluster
//  result   | m_valid / m_ready    | m_sector_lba, m_cluster, m_status
//  config   | cfg_we (no wait)     | cfg_index, cfg_data
//
// A start goes straight to classification; a step first reads two table bytes on the
// single RAM port. A valid cluster then runs the shift-add sector unit, one
// multiplier bit per cycle. A step with no chain active or a bad/end cluster skips
// the multiply.
// One item at a time: s_ready is high only while the sequencer is idle.
// The result sits in an output register; the sequencer returns to idle once it
// is loaded, so a stalled m_ready holds back only the next start or step.
// Reset (aresetn, synchronous) clears the chain and the registers to their
// defaults; the table RAM is not cleared.
`include "fat12_cluster_chain_walker_unit_assert.svh"

module fat12_cluster_chain_walker_unit #(
    parameter int FAT_BYTES = 8192
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [12:0] s_table_address,
    input  logic [7:0]  s_table_byte,
    input  logic [11:0] s_first_cluster,
    // result items
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_sector_lba,
    output logic [11:0] m_cluster,
    output logic [1:0]  m_status,
    // configuration
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import fcw_pkg::*;

    localparam int          ADDR_W    = $clog2(FAT_BYTES);
    localparam logic [13:0] FAT_LIMIT = 14'(FAT_BYTES);

    fsm_state_t state_reg, state_next;

    // chain state
    logic [11:0] cur_reg, cur_next;
    logic        active_reg, active_next;
    // per-item working registers
    logic [11:0] cand_reg, cand_next;
    logic [12:0] idx_reg, idx_next;
    logic [7:0]  lo_reg, lo_next;
    logic        lo_oob_reg, lo_oob_next;
    logic        hi_oob_reg, hi_oob_next;
    // pending result
    logic [31:0] pend_lba_reg, pend_lba_next;
    logic [11:0] pend_cluster_reg, pend_cluster_next;
    logic [1:0]  pend_status_reg, pend_status_next;
    // output register
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_lba_reg, m_lba_next;
    logic [11:0] m_cluster_reg, m_cluster_next;
    logic [1:0]  m_status_reg, m_status_next;
    // configuration
    logic [31:0] dsl_reg;
    logic [7:0]  spc_reg;

    logic        accept;
    logic        out_free;
    logic [13:0] idx_hi;
    logic [15:0] pair;
    logic [11:0] next_entry;
    logic        cls_bad, cls_end, cls_valid;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_rdata;

    logic              mul_start;
    mul_stat_t         mul_stat;
    logic [31:0]       mul_result;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign idx_hi   = {1'b0, idx_reg} + 14'd1;

    // byte pair: out-of-table bytes read as zero
    assign pair = {hi_oob_reg ? 8'd0 : ram_rdata, lo_oob_reg ? 8'd0 : lo_reg};
    // even cluster: low 12 bits; odd: upper 12 bits
    assign next_entry = cur_reg[0] ? pair[15:4] : pair[11:0];

    assign cls_bad   = cand_reg < FIRST_CLUSTER;
    assign cls_end   = cand_reg >= ENTRY_END;
    assign cls_valid = !cls_bad && !cls_end;

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_kind == KIND_START) begin
                        state_next = ST_CLASS;
                    end else if (s_kind == KIND_STEP) begin
                        state_next = active_reg ? ST_RD_LO : ST_DONE;
                    end
                end
            end
            ST_RD_LO:    state_next = ST_RD_HI;
            ST_RD_HI:    state_next = ST_PAIR;
            ST_PAIR:     state_next = ST_CLASS;
            ST_CLASS:    state_next = cls_valid ? ST_MUL_WAIT : ST_DONE;
            ST_MUL_WAIT: begin
                if (mul_stat.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // ---------------- outputs and datapath ----------------
    always_comb begin
        s_ready           = 1'b0;
        ram_we            = 1'b0;
        ram_addr          = s_table_address[ADDR_W-1:0];
        mul_start         = 1'b0;
        cur_next          = cur_reg;
        active_next       = active_reg;
        cand_next         = cand_reg;
        idx_next          = idx_reg;
        lo_next           = lo_reg;
        lo_oob_next       = lo_oob_reg;
        hi_oob_next       = hi_oob_reg;
        pend_lba_next     = pend_lba_reg;
        pend_cluster_next = pend_cluster_reg;
        pend_status_next  = pend_status_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_lba_next        = m_lba_reg;
        m_cluster_next    = m_cluster_reg;
        m_status_next     = m_status_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    if (s_kind == KIND_WRITE) begin
                        // writes past the table are dropped
                        ram_we = {1'b0, s_table_address} < FAT_LIMIT;
                    end
                    cand_next = s_first_cluster;
                    // entry offset = cluster * 3 / 2
                    idx_next  = {1'b0, cur_reg} + {2'b00, cur_reg[11:1]};
                    // step with no chain: end, sector 0
                    pend_lba_next     = '0;
                    pend_cluster_next = cur_reg;
                    pend_status_next  = STATUS_END;
                end
            end
            ST_RD_LO: begin
                ram_addr    = idx_reg[ADDR_W-1:0];
                lo_oob_next = {1'b0, idx_reg} >= FAT_LIMIT;
            end
            ST_RD_HI: begin
                ram_addr    = idx_hi[ADDR_W-1:0];
                hi_oob_next = idx_hi >= FAT_LIMIT;
                lo_next     = ram_rdata;
            end
            ST_PAIR: begin
                cand_next = next_entry;
            end
            ST_CLASS: begin
                pend_lba_next     = '0;
                pend_cluster_next = cand_reg;
                if (cls_bad) begin
                    pend_status_next = STATUS_BAD;
                    active_next      = 1'b0;
                end else if (cls_end) begin
                    pend_status_next = STATUS_END;
                    active_next      = 1'b0;
                end else begin
                    pend_status_next = STATUS_VALID;
                    active_next      = 1'b1;
                    cur_next         = cand_reg;
                    mul_start        = 1'b1;
                end
            end
            ST_MUL_WAIT: begin
                if (mul_stat.done) begin
                    pend_lba_next = mul_result;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_lba_next     = pend_lba_reg;
                    m_cluster_next = pend_cluster_reg;
                    m_status_next  = pend_status_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cur_reg     <= '0;
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            dsl_reg     <= DATA_START_RESET;
            spc_reg     <= SPC_RESET;
        end else begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_DATA_START: dsl_reg <= cfg_data;
                    REG_SPC:        spc_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
        end
        cand_reg         <= cand_next;
        idx_reg          <= idx_next;
        lo_reg           <= lo_next;
        lo_oob_reg       <= lo_oob_next;
        hi_oob_reg       <= hi_oob_next;
        pend_lba_reg     <= pend_lba_next;
        pend_cluster_reg <= pend_cluster_next;
        pend_status_reg  <= pend_status_next;
        m_lba_reg        <= m_lba_next;
        m_cluster_reg    <= m_cluster_next;
        m_status_reg     <= m_status_next;
    end

    fcw_ram #(
        .WIDTH (8),
        .DEPTH (FAT_BYTES)
    ) u_fat_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_table_byte),
        .rdata (ram_rdata)
    );

    // sector = data_start + (cluster - 2) * sectors_per_cluster
    fcw_mul u_lba_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (cand_reg - FIRST_CLUSTER),
        .mult    (spc_reg),
        .base    (dsl_reg),
        .stat    (mul_stat),
        .result  (mul_result)
    );

    assign m_valid      = m_valid_reg;
    assign m_sector_lba = m_lba_reg;
    assign m_cluster    = m_cluster_reg;
    assign m_status     = m_status_reg;

    `FCW_ASSERT_NOW(a_lba_zero_unless_valid, m_valid && (m_status != STATUS_VALID),
        m_sector_lba == 32'd0, "sector address nonzero on end or bad result")
    `FCW_ASSERT_NOW(a_valid_cluster_range, m_valid && (m_status == STATUS_VALID),
        (m_cluster >= FIRST_CLUSTER) && (m_cluster < ENTRY_END),
        "valid result carries a bad or end cluster")
    `FCW_ASSERT_NOW(a_mul_only_in_wait, mul_stat.busy || mul_stat.done,
        state_reg == ST_MUL_WAIT, "sector unit running outside its wait state")
    `FCW_ASSERT_NEXT(a_chain_follows_valid, (state_reg == ST_CLASS) && cls_valid,
        active_reg && (cur_reg == $past(cand_reg)), "chain not updated on valid cluster")

endmodule

// ----- dv/tb_fat12_cluster_chain_walker_unit.sv -----
// Self-checking testbench for the FAT12 cluster chain walker: table loads, chain walks, registers.
module tb_fat12_cluster_chain_walker_unit;
    import fcw_pkg::*;

    // kind code the block must ignore
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    // start/step/write items to send before the stimulus stops
    localparam int ITEM_TARGET = 1850;
    // cycles to let pass once the last result is in
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [31:0] lba;
        logic [11:0] clus;
        logic [1:0]  status;
    } sector_answer_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_kind;
    logic [12:0] s_table_address;
    logic [7:0]  s_table_byte;
    logic [11:0] s_first_cluster;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_sector_lba;
    logic [11:0] m_cluster;
    logic [1:0]  m_status;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;

    // Shadow of the block: table contents, which bytes were loaded, the walk
    // position and the two layout registers (reset values until programmed).
    bit [7:0]    fat_copy [0:8191];
    bit          fat_written [0:8191];
    logic        walk_active = 1'b0;
    logic [11:0] walk_cluster = 12'd0;
    logic [31:0] data_start_copy = DATA_START_RESET;
    logic [7:0]  spc_copy = SPC_RESET;

    // Answers owed by the block, oldest first.
    sector_answer_t expected_sectors [$];
    sector_answer_t want_result;

    int sent_items = 0;
    int mismatch_count = 0;
    // When set, neither side idles.
    bit steady = 1'b0;

    fat12_cluster_chain_walker_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_table_address (s_table_address),
        .s_table_byte    (s_table_byte),
        .s_first_cluster (s_first_cluster),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sector_lba    (m_sector_lba),
        .m_cluster       (m_cluster),
        .m_status        (m_status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Sort a cluster number into valid / end / bad, owe one answer, and move
    // the walk. Only a valid cluster becomes the new walk position.
    task automatic classify_cluster(input logic [11:0] clus);
        sector_answer_t ans;
        ans.lba  = 32'd0;
        ans.clus = clus;
        if (clus < FIRST_CLUSTER) begin
            ans.status  = STATUS_BAD;
            walk_active = 1'b0;
        end else if (clus >= ENTRY_END) begin
            ans.status  = STATUS_END;
            walk_active = 1'b0;
        end else begin
            ans.status   = STATUS_VALID;
            // wraps modulo 2^32, any sectors-per-cluster value
            ans.lba      = data_start_copy + ({20'd0, clus} - 32'd2) * {24'd0, spc_copy};
            walk_active  = 1'b1;
            walk_cluster = clus;
        end
        expected_sectors.push_back(ans);
    endtask

    // Apply one accepted item to the shadow and owe its answer, if any.
    task automatic predict_walk_item(input logic [1:0] kind, input logic [12:0] addr,
                                     input logic [7:0] tbyte, input logic [11:0] first);
        int          idx;
        logic [15:0] pair;
        sector_answer_t ans;
        case (kind)
            KIND_WRITE: begin
                fat_copy[addr]    = tbyte;
                fat_written[addr] = 1'b1;
            end
            KIND_START: classify_cluster(first);
            KIND_STEP: begin
                if (!walk_active) begin
                    // no chain: end of chain, parked cluster, no sector
                    ans.lba    = 32'd0;
                    ans.clus   = walk_cluster;
                    ans.status = STATUS_END;
                    expected_sectors.push_back(ans);
                end else begin
                    // 12-bit entry in the little-endian pair at cluster*3/2;
                    // odd clusters use the upper 12 bits
                    idx  = int'(walk_cluster) * 3 / 2;
                    pair = {fat_copy[idx + 1], fat_copy[idx]};
                    classify_cluster(walk_cluster[0] ? pair[15:4] : pair[11:0]);
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Present one item at a falling edge, after a random gap, and hold it until
    // the block takes it. Valid stays high on return so back-to-back items
    // never see a low pulse.
    task automatic send_item(input logic [1:0] kind, input logic [12:0] addr,
                             input logic [7:0] tbyte, input logic [11:0] first);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 37) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_kind          <= kind;
        s_table_address <= addr;
        s_table_byte    <= tbyte;
        s_first_cluster <= first;
        do @(posedge aclk); while (!s_ready);
        predict_walk_item(kind, addr, tbyte, first);
        if (kind != KIND_UNUSED)
            sent_items++;
    endtask

    // Rewrite the 12-bit entry of one cluster, keeping the neighbor's nibble.
    task automatic set_entry(input logic [11:0] clus, input logic [11:0] val);
        int          idx;
        logic [15:0] pair;
        idx  = int'(clus) * 3 / 2;
        pair = {fat_copy[idx + 1], fat_copy[idx]};
        if (clus[0])
            pair[15:4] = val;
        else
            pair[11:0] = val;
        send_item(KIND_WRITE, 13'(idx), pair[7:0], 12'($urandom));
        send_item(KIND_WRITE, 13'(idx + 1), pair[15:8], 12'($urandom));
    endtask

    // Step the walk. Table bytes the step would read but that were never
    // loaded get random contents first.
    task automatic step_item();
        int idx;
        int b;
        if (walk_active) begin
            idx = int'(walk_cluster) * 3 / 2;
            for (b = idx; b <= idx + 1; b++)
                if (!fat_written[b])
                    send_item(KIND_WRITE, 13'(b), 8'($urandom), 12'($urandom));
        end
        send_item(KIND_STEP, 13'($urandom), 8'($urandom), 12'($urandom));
    endtask

    // Random noise: stray write, stray start, step (after any table loads it needs), or ignored kind.
    task automatic noise_item();
        case ($urandom_range(3))
            0: send_item(KIND_WRITE, 13'($urandom), 8'($urandom), 12'($urandom));
            1: send_item(KIND_START, 13'($urandom), 8'($urandom), 12'($urandom));
            2: step_item();
            default: send_item(KIND_UNUSED, 13'($urandom), 8'($urandom), 12'($urandom));
        endcase
    endtask

    // Half the clusters low in the table so neighbors share bytes often.
    function automatic logic [11:0] pick_cluster();
        if ($urandom_range(1) == 0)
            return 12'($urandom_range(2, 48));
        return 12'($urandom_range(2, 32'hFF7));
    endfunction

    // Lay out a file chain in the table, start it and walk to the end, plus up to
    // two steps past the end. Most chains close with an end mark; some with
    // a bad link, some run off into whatever the table holds.
    task automatic walk_random_file();
        logic [11:0] chain [8];
        logic [11:0] tail;
        int          len;
        int          steps;
        int          i;
        len = $urandom_range(1, 8);
        for (i = 0; i < len; i++)
            chain[i] = pick_cluster();
        case ($urandom_range(9))
            0: tail = 12'($urandom_range(1));
            1: tail = pick_cluster();
            default: tail = 12'($urandom_range(32'hFF8, 32'hFFF));
        endcase
        for (i = 0; i < len; i++) begin
            if (i == len - 1)
                set_entry(chain[i], tail);
            else
                set_entry(chain[i], chain[i + 1]);
        end
        send_item(KIND_START, 13'($urandom), 8'($urandom), chain[0]);
        steps = len + $urandom_range(2);
        for (i = 0; i < steps; i++) begin
            if ($urandom_range(9) == 0)
                noise_item();
            step_item();
        end
    endtask

    task automatic run_files(input int count);
        int n;
        for (n = 0; n < count; n++)
            walk_random_file();
    endtask

    task automatic mix_until(input int target);
        while (sent_items < target) begin
            if ($urandom_range(3) != 0)
                walk_random_file();
            else
                noise_item();
        end
    endtask

    // Registers change only with the block idle: all answers in, then time
    // for a trailing table write to land.
    task automatic program_layout(input logic [31:0] start_lba, input logic [7:0] spc);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_sectors.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DATA_START;
        cfg_data  <= start_lba;
        @(negedge aclk);
        cfg_index <= REG_SPC;
        cfg_data  <= {24'd0, spc};
        @(negedge aclk);
        cfg_we <= 1'b0;
        data_start_copy = start_lba;
        spc_copy        = spc;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Receiver stalls with probability 37 in 100 unless in a steady stretch.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= steady || ($urandom_range(99) >= 37);
        end
    end

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    // Every result item taken is held against the oldest answer owed.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_sectors.size() == 0) begin
                flag_mismatch("unexpected result item, cluster", 32'd0, 32'(m_cluster));
            end else begin
                want_result = expected_sectors.pop_front();
                if (m_sector_lba !== want_result.lba)
                    flag_mismatch("sector_lba", want_result.lba, m_sector_lba);
                if (m_cluster !== want_result.clus)
                    flag_mismatch("cluster", 32'(want_result.clus), 32'(m_cluster));
                if (m_status !== want_result.status)
                    flag_mismatch("status", 32'(want_result.status), 32'(m_status));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Corner cases with the reset layout (cluster 2 at sector 33, one sector
    // per cluster).
    task automatic test_directed_cases();
        // step before any chain: end of chain on parked cluster 0
        step_item();
        // bad and end-mark first clusters
        send_item(KIND_START, 13'd0, 8'd0, 12'd0);
        send_item(KIND_START, 13'd0, 8'd0, 12'd1);
        send_item(KIND_START, 13'h1FFF, 8'hFF, ENTRY_END);
        send_item(KIND_START, 13'h1FFF, 8'hFF, 12'hFFF);
        // 2 -> 3 -> end: even and odd entries sharing byte 4, then a step
        // past the end
        set_entry(12'd2, 12'd3);
        set_entry(12'd3, 12'hFFF);
        send_item(KIND_START, 13'd0, 8'd0, 12'd2);
        step_item();
        step_item();
        step_item();
        // link to cluster 1 is bad
        set_entry(12'd4, 12'd1);
        send_item(KIND_START, 13'd0, 8'd0, 12'd4);
        step_item();
        // 5 -> highest valid cluster -> lowest end mark
        set_entry(12'hFF7, ENTRY_END);
        set_entry(12'd5, 12'hFF7);
        send_item(KIND_START, 13'd0, 8'd0, 12'd5);
        step_item();
        step_item();
        // table edges and the ignored kind
        send_item(KIND_WRITE, 13'd0, 8'h00, 12'hFFF);
        send_item(KIND_WRITE, 13'h1FFF, 8'hFF, 12'h000);
        send_item(KIND_UNUSED, 13'h1FFF, 8'hFF, 12'hFFF);
    endtask

    // Layout extremes, including sectors-per-cluster 0 and above 128 and
    // sector addresses that wrap.
    task automatic test_register_extremes();
        program_layout(32'd0, 8'd1);
        run_files(4);
        program_layout(32'hFFFF_FFFF, 8'd128);
        run_files(4);
        program_layout(32'($urandom), 8'd0);
        run_files(3);
        program_layout(32'($urandom), 8'd255);
        run_files(3);
    endtask

    // Bulk: mostly well-formed file walks with noise, a steady stretch in the
    // middle, a fresh layout for each part.
    task automatic test_random_chains();
        program_layout(32'($urandom), 8'($urandom_range(1, 128)));
        mix_until(900);
        program_layout(32'($urandom), 8'($urandom_range(1, 128)));
        steady = 1'b1;
        mix_until(1250);
        program_layout(32'($urandom), 8'($urandom_range(1, 128)));
        steady = 1'b0;
        mix_until(ITEM_TARGET);
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_kind          = KIND_WRITE;
        s_table_address = 13'd0;
        s_table_byte    = 8'd0;
        s_first_cluster = 12'd0;
        cfg_we          = 1'b0;
        cfg_index       = REG_DATA_START;
        cfg_data        = 32'd0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_register_extremes();
        test_random_chains();

        // drain: every owed answer in, then a margin for stray items
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_sectors.size() != 0)
            @(posedge aclk);
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/fcw_pkg.sv
rtl/fcw_ram.sv
rtl/fcw_mul.sv
rtl/fat12_cluster_chain_walker_unit.sv
dv/tb_fat12_cluster_chain_walker_unit.sv
